[src/priority_voice_allocator_macros.svh]
// Assertion helpers for files that check their own logic.
// Each one samples on the rising edge of clk and is switched off in reset.
`ifndef PRIORITY_VOICE_ALLOCATOR_MACROS_SVH
`define PRIORITY_VOICE_ALLOCATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PVA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PVA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/pva_pkg.sv]
`timescale 1ns / 1ps

package pva_pkg;

  localparam int CMD_W    = 2;
  localparam int LEVEL_W  = 8;
  localparam int PRIO_W   = 8;
  localparam int HANDLE_W = 6;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;
  localparam int CFG_W    = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;
  localparam logic [CMD_W-1:0] CMD_KILL  = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_VOICE  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VOICES     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MUSIC_PRIORITY = 1'd1;

  localparam logic [HANDLE_W-1:0] MAX_VOICES_RESET     = 6'd32;
  localparam logic [PRIO_W-1:0]   MUSIC_PRIORITY_RESET = 8'd255;

endpackage

[src/pva_req_if.sv]
`timescale 1ns / 1ps

interface pva_req_if
  import pva_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [PRIO_W-1:0]   priority_req;
  logic [HANDLE_W-1:0] handle;
  logic [LEVEL_W-1:0]  left_level;
  logic [LEVEL_W-1:0]  right_level;

  modport source (
    output valid, cmd, priority_req, handle, left_level, right_level,
    input  ready
  );
  modport sink (
    input  valid, cmd, priority_req, handle, left_level, right_level,
    output ready
  );
endinterface

[src/pva_rsp_if.sv]
`timescale 1ns / 1ps

interface pva_rsp_if
  import pva_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] granted_handle;
  logic                stolen;
  logic [HANDLE_W-1:0] stolen_handle;
  logic                available;
  logic [COUNT_W-1:0]  voices_playing;

  modport source (
    output valid, status, granted_handle, stolen, stolen_handle, available,
           voices_playing,
    input  ready
  );
  modport sink (
    input  valid, status, granted_handle, stolen, stolen_handle, available,
           voices_playing,
    output ready
  );
endinterface

[src/pva_cell.sv]
`timescale 1ns / 1ps

module pva_cell
  import pva_pkg::*;
#(
  parameter int IDX = 1,
  parameter int IW  = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [2*IW+3+4*PRIO_W-1:0] ctl,
  input  logic [5*IW+1+3*PRIO_W:0]   rec_in,
  output logic [5*IW+1+3*PRIO_W:0]   rec_out
);

  typedef struct packed {
    logic              valid;
    logic [IW-1:0]     all_cnt;
    logic [IW-1:0]     pool_cnt;
    logic [IW-1:0]     music_cnt;
    logic [IW-1:0]     vic;
    logic [PRIO_W-1:0] vic_prio;
    logic [LEVEL_W-1:0] vic_left;
    logic [LEVEL_W-1:0] vic_right;
    logic [IW-1:0]     free2;
    logic              tgt;
  } scan_t;

  typedef struct packed {
    logic [IW-1:0]      eff_max;
    logic [PRIO_W-1:0]  music;
    logic [IW-1:0]      probe;
    logic               kill;
    logic               clr;
    logic               wr;
    logic [PRIO_W-1:0]  prio;
    logic [LEVEL_W-1:0] left;
    logic [LEVEL_W-1:0] right;
  } ctl_t;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  ctl_t  c;
  scan_t ri;
  scan_t ro;
  scan_t rnext;

  logic               active;
  logic [PRIO_W-1:0]  prio;
  logic [LEVEL_W-1:0] lvl_left;
  logic [LEVEL_W-1:0] lvl_right;
  logic               in_pool;
  logic               here;
  logic               take;

  assign c       = ctl_t'(ctl);
  assign ri      = scan_t'(rec_in);
  assign rec_out = ro;

  assign in_pool = (MY_IDX <= c.eff_max);
  // The probe handle selects this slot both for the free lookup and for writes.
  assign here    = (c.probe == MY_IDX);

  // A later slot displaces the candidate only if strictly better.
  assign take = active && in_pool &&
                ((ri.vic == '0) || (prio < ri.vic_prio) ||
                 ((prio == ri.vic_prio) && (lvl_left < ri.vic_left) &&
                  (lvl_right < ri.vic_right)));

  always_comb begin
    rnext           = ri;
    rnext.all_cnt   = ri.all_cnt + IW'(active);
    rnext.pool_cnt  = ri.pool_cnt + IW'(active && in_pool);
    rnext.music_cnt = ri.music_cnt + IW'(active && (prio == c.music));
    if (take) begin
      rnext.vic       = MY_IDX;
      rnext.vic_prio  = prio;
      rnext.vic_left  = lvl_left;
      rnext.vic_right = lvl_right;
    end
    if ((ri.free2 == '0) && !active && in_pool && (MY_IDX >= IW'(2))) begin
      rnext.free2 = MY_IDX;
    end
    if (here) begin
      rnext.tgt = active;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ro.valid <= 1'b0;
    end else begin
      ro.valid <= ri.valid;
    end
    ro.all_cnt   <= rnext.all_cnt;
    ro.pool_cnt  <= rnext.pool_cnt;
    ro.music_cnt <= rnext.music_cnt;
    ro.vic       <= rnext.vic;
    ro.vic_prio  <= rnext.vic_prio;
    ro.vic_left  <= rnext.vic_left;
    ro.vic_right <= rnext.vic_right;
    ro.free2     <= rnext.free2;
    ro.tgt       <= rnext.tgt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (c.wr && here) begin
      active <= 1'b1;
    end else if ((c.clr && here) || (c.kill && active && (prio != c.music))) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (c.wr && here) begin
      prio      <= c.prio;
      lvl_left  <= c.left;
      lvl_right <= c.right;
    end
  end

endmodule

[src/priority_voice_allocator.sv]
// Voice slot allocator with priority based stealing.
// Requests arrive on the req channel (valid/ready) carrying a command, a
// priority, a handle and two levels; every request yields exactly one
// response on the rsp channel. Configuration (max_voices, music_priority)
// is written through cfg_we/cfg_addr/cfg_wdata; the user is bound to write
// it only while no request is open, as the block does not enforce this.
// Each slot lives in one cell of a chain; a scan record enters the first
// cell and moves one cell per cycle, gathering counts, the steal candidate
// and the first free handle from 2 upward. An accepted request passes the
// start register, the chain of NUM_VOICES cells and the result register;
// no new request is taken until the previous response is in the output register.
// The response sits in an output register, so a new request is accepted
// while the previous response still waits; if the receiver stalls, the
// finished scan is held and the slot update is deferred until the output
// register is free. Reset is synchronous: all slots become inactive and
// the registers return to 32 voices and music priority 255. No clearing
// pass is needed, so requests are taken in the first cycle after reset.
`timescale 1ns / 1ps

`include "priority_voice_allocator_macros.svh"

module priority_voice_allocator
  import pva_pkg::*;
#(
  parameter int NUM_VOICES = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata,
  pva_req_if.sink              req,
  pva_rsp_if.source            rsp
);

  localparam int CW = $clog2(NUM_VOICES + 1);
  localparam int IW = (CW > HANDLE_W) ? CW : HANDLE_W;
  localparam logic [IW-1:0] NV = IW'(NUM_VOICES);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  typedef struct packed {
    logic              valid;
    logic [IW-1:0]     all_cnt;
    logic [IW-1:0]     pool_cnt;
    logic [IW-1:0]     music_cnt;
    logic [IW-1:0]     vic;
    logic [PRIO_W-1:0] vic_prio;
    logic [LEVEL_W-1:0] vic_left;
    logic [LEVEL_W-1:0] vic_right;
    logic [IW-1:0]     free2;
    logic              tgt;
  } scan_t;

  typedef struct packed {
    logic [IW-1:0]      eff_max;
    logic [PRIO_W-1:0]  music;
    logic [IW-1:0]      probe;
    logic               kill;
    logic               clr;
    logic               wr;
    logic [PRIO_W-1:0]  prio;
    logic [LEVEL_W-1:0] left;
    logic [LEVEL_W-1:0] right;
  } ctl_t;

  logic [1:0]          state;
  logic [1:0]          state_next;
  logic [HANDLE_W-1:0] max_voices;
  logic [PRIO_W-1:0]   music_priority;
  logic [IW-1:0]       eff_max;
  logic [IW-1:0]       mv_ext;

  logic [CMD_W-1:0]    cmd_q;
  logic [PRIO_W-1:0]   prio_q;
  logic [HANDLE_W-1:0] hnd_q;
  logic [LEVEL_W-1:0]  left_q;
  logic [LEVEL_W-1:0]  right_q;
  logic                start;

  scan_t               rec [0:NUM_VOICES];
  logic [NUM_VOICES-1:0] chain_vld;
  scan_t               fin;
  ctl_t                ctl;

  logic                accept;
  logic                fire;
  logic                full;
  logic                vic_ok;
  logic                free_ok;
  logic [IW-1:0]       hnd_ext;
  logic [IW-1:0]       grant;
  logic [IW-1:0]       count_next;
  logic [STATUS_W-1:0] status_next;
  logic [IW-1:0]       granted_next;
  logic                stolen_next;
  logic [IW-1:0]       stolen_h_next;
  logic                avail_next;

  logic                rsp_valid;
  logic [STATUS_W-1:0] rsp_status;
  logic [HANDLE_W-1:0] rsp_granted;
  logic                rsp_stolen;
  logic [HANDLE_W-1:0] rsp_stolen_h;
  logic                rsp_avail;
  logic [COUNT_W-1:0]  rsp_count;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_voices     <= MAX_VOICES_RESET;
      music_priority <= MUSIC_PRIORITY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MAX_VOICES:     max_voices     <= cfg_wdata[HANDLE_W-1:0];
        CFG_MUSIC_PRIORITY: music_priority <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Zero acts as one slot, anything beyond the chain as the whole chain.
  assign mv_ext  = IW'(max_voices);
  assign eff_max = (max_voices == '0) ? IW'(1) : ((mv_ext > NV) ? NV : mv_ext);

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= req.cmd;
      prio_q  <= req.priority_req;
      hnd_q   <= req.handle;
      left_q  <= req.left_level;
      right_q <= req.right_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      start <= accept;
    end
  end

  always_comb begin
    rec[0]       = '0;
    rec[0].valid = start;
  end

  for (genvar i = 0; i < NUM_VOICES; i++) begin : g_cell
    pva_cell #(
      .IDX (i + 1),
      .IW  (IW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .rec_in  (rec[i]),
      .rec_out (rec[i+1])
    );
    assign chain_vld[i] = rec[i+1].valid;
  end

  always_ff @(posedge clk) begin
    if (rec[NUM_VOICES].valid) begin
      fin <= rec[NUM_VOICES];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept) state_next = ST_SCAN;
      ST_SCAN:   if (rec[NUM_VOICES].valid) state_next = ST_FINISH;
      ST_FINISH: if (fire) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decision from the finished scan.
  assign fire    = (state == ST_FINISH) && (!rsp_valid || rsp.ready);
  assign full    = (fin.pool_cnt >= eff_max);
  assign vic_ok  = (fin.vic != '0) && (fin.vic_prio <= prio_q);
  assign hnd_ext = IW'(hnd_q);
  assign free_ok = (hnd_ext != '0) && (hnd_ext <= eff_max) && fin.tgt;
  // When the pool is full the stolen slot is the only one left to grant.
  assign grant   = full ? fin.vic : ((fin.free2 != '0) ? fin.free2 : IW'(1));

  always_comb begin
    status_next   = STATUS_OK;
    granted_next  = '0;
    stolen_next   = 1'b0;
    stolen_h_next = '0;
    avail_next    = 1'b0;
    count_next    = fin.all_cnt;
    unique case (cmd_q)
      CMD_ALLOC: begin
        if (!full) begin
          granted_next = grant;
          count_next   = fin.all_cnt + IW'(1);
        end else if (vic_ok) begin
          granted_next  = grant;
          stolen_next   = 1'b1;
          stolen_h_next = fin.vic;
        end else begin
          status_next = STATUS_NO_VOICE;
        end
      end
      CMD_FREE: begin
        if (free_ok) begin
          count_next = fin.all_cnt - IW'(1);
        end else begin
          status_next = STATUS_NOT_FOUND;
        end
      end
      CMD_QUERY: begin
        avail_next = !full || vic_ok;
      end
      CMD_KILL: begin
        count_next = fin.music_cnt;
      end
      default: ;
    endcase
  end

  always_comb begin
    ctl.eff_max = eff_max;
    ctl.music   = music_priority;
    ctl.probe   = (state == ST_FINISH && cmd_q == CMD_ALLOC) ? grant : hnd_ext;
    ctl.kill    = fire && (cmd_q == CMD_KILL);
    ctl.clr     = fire && (cmd_q == CMD_FREE) && free_ok;
    ctl.wr      = fire && (cmd_q == CMD_ALLOC) && (!full || vic_ok);
    ctl.prio    = prio_q;
    ctl.left    = left_q;
    ctl.right   = right_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_status   <= status_next;
      rsp_granted  <= granted_next[HANDLE_W-1:0];
      rsp_stolen   <= stolen_next;
      rsp_stolen_h <= stolen_h_next[HANDLE_W-1:0];
      rsp_avail    <= avail_next;
      rsp_count    <= count_next[COUNT_W-1:0];
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.status         = rsp_status;
  assign rsp.granted_handle = rsp_granted;
  assign rsp.stolen         = rsp_stolen;
  assign rsp.stolen_handle  = rsp_stolen_h;
  assign rsp.available      = rsp_avail;
  assign rsp.voices_playing = rsp_count;

  `PVA_ASSERT_NOW(a_one_scan, 1'b1, $onehot0(chain_vld), "more than one scan in the chain")
  `PVA_ASSERT_NOW(a_scan_state, rec[NUM_VOICES].valid, state == ST_SCAN,
                  "scan finished outside the scan state")
  `PVA_ASSERT_NOW(a_pool_count, state == ST_FINISH, fin.pool_cnt <= eff_max,
                  "active count in pool exceeds slots in use")
  `PVA_ASSERT_NEXT(a_steal_grant, fire && stolen_next,
                   rsp.granted_handle == rsp.stolen_handle,
                   "stolen slot not the one granted")

endmodule

[dv/voice_alloc_checker.sv]
`timescale 1ns / 1ps

module voice_alloc_checker
  import pva_pkg::*;
#(
  parameter int NUM_VOICES = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata,
  pva_req_if                   req,
  pva_rsp_if                   rsp,
  output int                   errors,
  output int                   outstanding
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] granted_handle;
    logic                stolen;
    logic [HANDLE_W-1:0] stolen_handle;
    logic                available;
    logic [COUNT_W-1:0]  voices_playing;
  } voice_result_t;

  logic [HANDLE_W-1:0] max_voices;
  logic [PRIO_W-1:0]   music_priority;
  logic                busy       [1:NUM_VOICES];
  logic [PRIO_W-1:0]   voice_prio [1:NUM_VOICES];
  logic [LEVEL_W-1:0]  voice_left [1:NUM_VOICES];
  logic [LEVEL_W-1:0]  voice_right[1:NUM_VOICES];

  voice_result_t awaited_results[$];
  int            mismatches = 0;

  // A register value of zero behaves as one slot; values beyond the pool are clamped.
  function automatic int slots_in_use();
    if (max_voices == 0) return 1;
    if (max_voices > NUM_VOICES) return NUM_VOICES;
    return int'(max_voices);
  endfunction

  function automatic int count_busy(input int upto);
    int n;
    n = 0;
    for (int h = 1; h <= upto; h++) if (busy[h]) n++;
    return n;
  endfunction

  // Lowest priority wins; at equal priority a later voice takes over only when
  // both of its levels are strictly lower.
  function automatic int weakest_voice();
    int m;
    int v;
    m = slots_in_use();
    v = 0;
    for (int h = 1; h <= m; h++) begin
      if (!busy[h]) continue;
      if (v == 0 || voice_prio[h] < voice_prio[v] ||
          (voice_prio[h] == voice_prio[v] &&
           voice_left[h] < voice_left[v] && voice_right[h] < voice_right[v]))
        v = h;
    end
    return v;
  endfunction

  function automatic voice_result_t serve_request(
    input logic [CMD_W-1:0]    c,
    input logic [PRIO_W-1:0]   p,
    input logic [HANDLE_W-1:0] hnd,
    input logic [LEVEL_W-1:0]  lvl_l,
    input logic [LEVEL_W-1:0]  lvl_r
  );
    voice_result_t res;
    int            m;
    int            v;
    int            h;
    bit            room;
    res = '0;
    m   = slots_in_use();
    case (c)
      CMD_ALLOC: begin
        room = 1'b1;
        if (count_busy(m) == m) begin
          v = weakest_voice();
          if (v != 0 && voice_prio[v] <= p) begin
            busy[v]           = 1'b0;
            res.stolen        = 1'b1;
            res.stolen_handle = HANDLE_W'(v);
          end else begin
            room = 1'b0;
          end
        end
        if (room) begin
          // The search begins one past handle 1 and wraps round to it last.
          h = 1;
          do begin
            h++;
            if (h > m) h = 1;
          end while (busy[h]);
          busy[h]            = 1'b1;
          voice_prio[h]      = p;
          voice_left[h]      = lvl_l;
          voice_right[h]     = lvl_r;
          res.granted_handle = HANDLE_W'(h);
        end else begin
          res.status = STATUS_NO_VOICE;
        end
      end
      CMD_FREE: begin
        if (hnd >= 1 && hnd <= m && busy[hnd]) busy[hnd] = 1'b0;
        else res.status = STATUS_NOT_FOUND;
      end
      CMD_QUERY: begin
        if (count_busy(m) < m) begin
          res.available = 1'b1;
        end else begin
          v = weakest_voice();
          res.available = (v != 0 && voice_prio[v] <= p);
        end
      end
      default: begin
        for (int k = 1; k <= NUM_VOICES; k++)
          if (busy[k] && voice_prio[k] != music_priority) busy[k] = 1'b0;
      end
    endcase
    res.voices_playing = COUNT_W'(count_busy(NUM_VOICES));
    return res;
  endfunction

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    voice_result_t want;
    if (rst) begin
      max_voices     = MAX_VOICES_RESET;
      music_priority = MUSIC_PRIORITY_RESET;
      for (int h = 1; h <= NUM_VOICES; h++) begin
        busy[h]        = 1'b0;
        voice_prio[h]  = '0;
        voice_left[h]  = '0;
        voice_right[h] = '0;
      end
      awaited_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CFG_MAX_VOICES) max_voices = cfg_wdata[HANDLE_W-1:0];
        else music_priority = cfg_wdata[PRIO_W-1:0];
      end
      // Retire the oldest expectation before adding one for a request taken on this edge.
      if (rsp.valid && rsp.ready) begin
        if (awaited_results.size() == 0) begin
          $error("response arrived with no request outstanding");
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("status", want.status, rsp.status);
          compare_field("granted_handle", want.granted_handle, rsp.granted_handle);
          compare_field("stolen", want.stolen, rsp.stolen);
          compare_field("stolen_handle", want.stolen_handle, rsp.stolen_handle);
          compare_field("available", want.available, rsp.available);
          compare_field("voices_playing", want.voices_playing, rsp.voices_playing);
        end
      end
      if (req.valid && req.ready)
        awaited_results.push_back(serve_request(req.cmd, req.priority_req, req.handle,
                                                req.left_level, req.right_level));
    end
    errors      <= mismatches;
    outstanding <= awaited_results.size();
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
  import pva_pkg::*;

  localparam int NUM_VOICES      = 32;
  localparam int SEGMENTS        = 10;
  localparam int SEGMENT_ITEMS   = 200;
  localparam int SETTLE_CYCLES   = 50;
  localparam int TIMEOUT_NS      = 20_000_000;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [CFG_W-1:0]     cfg_wdata;

  int                   send_idle_pct = 35;
  int                   recv_idle_pct = 47;
  int                   span          = NUM_VOICES;
  logic [PRIO_W-1:0]    music         = MUSIC_PRIORITY_RESET;
  int                   errors;
  int                   outstanding;

  logic [CFG_W-1:0]     seg_max  [SEGMENTS] = '{8'd32, 8'd4, 8'd1, 8'd0, 8'd63,
                                                8'hC6, 8'd2, 8'd16, 8'd33, 8'd3};
  logic [CFG_W-1:0]     seg_music[SEGMENTS] = '{8'd255, 8'd0, 8'd3, 8'd5, 8'hFF,
                                                8'd1, 8'd7, 8'd0, 8'd2, 8'd4};

  pva_req_if req_ch ();
  pva_rsp_if rsp_ch ();

  priority_voice_allocator #(
    .NUM_VOICES (NUM_VOICES)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  voice_alloc_checker #(
    .NUM_VOICES (NUM_VOICES)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always #10 clk = ~clk;

  initial begin
    #TIMEOUT_NS;
    $display("tb: failure");
    $finish;
  end

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Entered and left just after a falling edge; valid is left high so that
  // back-to-back requests need no second assignment in one time step.
  task automatic send_request(
    input logic [CMD_W-1:0]    c,
    input logic [PRIO_W-1:0]   p,
    input logic [HANDLE_W-1:0] hnd,
    input logic [LEVEL_W-1:0]  lvl_l,
    input logic [LEVEL_W-1:0]  lvl_r
  );
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.cmd          <= c;
    req_ch.priority_req <= p;
    req_ch.handle       <= hnd;
    req_ch.left_level   <= lvl_l;
    req_ch.right_level  <= lvl_r;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    logic [HANDLE_W-1:0] m;
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (idx == CFG_MAX_VOICES) begin
      m    = data[HANDLE_W-1:0];
      span = (m == 0) ? 1 : (m > NUM_VOICES) ? NUM_VOICES : int'(m);
    end else begin
      music = data[PRIO_W-1:0];
    end
  endtask

  // Mostly allocations and frees of handles in range, with priorities packed
  // into a narrow band so that stealing and level tie-breaks are frequent.
  task automatic random_request();
    int                  pick;
    int                  band;
    logic [PRIO_W-1:0]   p;
    logic [LEVEL_W-1:0]  lvl_l;
    logic [LEVEL_W-1:0]  lvl_r;
    pick = $urandom_range(99);
    band = $urandom_range(9);
    if (band < 6) p = PRIO_W'($urandom_range(7));
    else if (band < 8) p = music;
    else p = PRIO_W'($urandom_range(255));
    if ($urandom_range(1)) begin
      lvl_l = LEVEL_W'($urandom_range(255));
      lvl_r = LEVEL_W'($urandom_range(255));
    end else begin
      lvl_l = LEVEL_W'($urandom_range(3));
      lvl_r = LEVEL_W'($urandom_range(3));
    end
    if (pick < 46)
      send_request(CMD_ALLOC, p, HANDLE_W'($urandom_range(63)), lvl_l, lvl_r);
    else if (pick < 78)
      send_request(CMD_FREE, p, HANDLE_W'($urandom_range(span, 1)), lvl_l, lvl_r);
    else if (pick < 91)
      send_request(CMD_QUERY, p, HANDLE_W'($urandom_range(63)), lvl_l, lvl_r);
    else if (pick < 94)
      send_request(CMD_KILL, p, HANDLE_W'($urandom_range(63)), lvl_l, lvl_r);
    else
      send_request(CMD_FREE, p, HANDLE_W'($urandom_range(63)), lvl_l, lvl_r);
  endtask

  initial begin
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_addr            = CFG_MAX_VOICES;
    cfg_wdata           = '0;
    req_ch.valid        = 1'b0;
    req_ch.cmd          = CMD_ALLOC;
    req_ch.priority_req = '0;
    req_ch.handle       = '0;
    req_ch.left_level   = '0;
    req_ch.right_level  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Default pool: field extremes, bad handles, and kill all sparing music.
    send_request(CMD_ALLOC, 8'd0, 6'd0, 8'd0, 8'd0);
    send_request(CMD_ALLOC, 8'd255, 6'd63, 8'd255, 8'd255);
    send_request(CMD_QUERY, 8'd0, 6'd0, 8'd0, 8'd0);
    send_request(CMD_FREE, 8'd0, 6'd0, 8'd0, 8'd0);
    send_request(CMD_FREE, 8'd0, 6'd33, 8'd0, 8'd0);
    send_request(CMD_FREE, 8'd0, 6'd32, 8'd0, 8'd0);
    send_request(CMD_KILL, 8'd0, 6'd0, 8'd0, 8'd0);
    settle();

    // A one-slot pool with a voice left above it: refusal and stealing.
    write_reg(CFG_MAX_VOICES, 8'd1);
    send_request(CMD_ALLOC, 8'd7, 6'd0, 8'd200, 8'd200);
    send_request(CMD_QUERY, 8'd6, 6'd0, 8'd0, 8'd0);
    send_request(CMD_ALLOC, 8'd6, 6'd0, 8'd1, 8'd1);
    send_request(CMD_FREE, 8'd0, 6'd3, 8'd0, 8'd0);
    send_request(CMD_ALLOC, 8'd7, 6'd0, 8'd10, 8'd10);
    settle();

    // A register value of zero still gives one slot; kill all spares the new music priority.
    write_reg(CFG_MAX_VOICES, 8'd0);
    write_reg(CFG_MUSIC_PRIORITY, 8'd7);
    send_request(CMD_QUERY, 8'd7, 6'd0, 8'd0, 8'd0);
    send_request(CMD_KILL, 8'd0, 6'd0, 8'd0, 8'd0);
    settle();

    // Equal priorities: the victim changes only when both levels are strictly lower.
    write_reg(CFG_MAX_VOICES, 8'd3);
    send_request(CMD_ALLOC, 8'd4, 6'd0, 8'd100, 8'd100);
    send_request(CMD_ALLOC, 8'd4, 6'd0, 8'd50, 8'd150);
    send_request(CMD_QUERY, 8'd3, 6'd0, 8'd0, 8'd0);
    send_request(CMD_ALLOC, 8'd4, 6'd0, 8'd0, 8'd0);
    send_request(CMD_ALLOC, 8'd4, 6'd0, 8'd255, 8'd0);
    send_request(CMD_FREE, 8'd0, 6'd3, 8'd0, 8'd0);
    send_request(CMD_ALLOC, 8'd9, 6'd0, 8'd1, 8'd2);
    settle();
    write_reg(CFG_MAX_VOICES, 8'd63);
    send_request(CMD_ALLOC, 8'd255, 6'd0, 8'd255, 8'd255);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      settle();
      if (seg < 4) begin
        send_idle_pct = 35;
        recv_idle_pct = 47;
      end else if (seg < 7) begin
        send_idle_pct = 47;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(CFG_MAX_VOICES, seg_max[seg]);
      write_reg(CFG_MUSIC_PRIORITY, seg_music[seg]);
      for (int n = 0; n < SEGMENT_ITEMS; n++) random_request();
    end

    settle();
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

[priority_voice_allocator.f]
+incdir+src
src/pva_pkg.sv
src/pva_req_if.sv
src/pva_rsp_if.sv
src/pva_cell.sv
src/priority_voice_allocator.sv
dv/voice_alloc_checker.sv
dv/tb.sv
